FILE: src/jrsl_pkg.sv
`default_nettype none

package jrsl_pkg;

  localparam int AngleW  = 32;
  localparam int MarginW = 16;
  localparam int HoldW   = 4;
  localparam int JointW  = 5;
  localparam int CfgIdxW = 1;
  localparam int CfgW    = 16;

  localparam logic [CfgIdxW-1:0] CfgVelMargin = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgServoHold = 1'b1;

  localparam logic [MarginW-1:0] VelMarginRst = 16'd6;
  localparam logic [HoldW-1:0]   ServoHoldRst = 4'd10;

  typedef struct packed {
    logic [JointW-1:0]        joint_index;
    logic signed [AngleW-1:0] ref_angle;
    logic signed [AngleW-1:0] meas_angle;
    logic                     servo_on;
    logic signed [AngleW-1:0] pos_lower;
    logic signed [AngleW-1:0] pos_upper;
    logic signed [AngleW-1:0] vel_lower_step;
    logic signed [AngleW-1:0] vel_upper_step;
    logic signed [AngleW-1:0] error_limit;
    logic                     masked;
  } in_t;

  typedef struct packed {
    logic signed [AngleW-1:0] out_angle;
    logic                     position_alarm;
    logic                     error_alarm;
    logic                     velocity_limited;
  } out_t;

  // per-joint state word held in memory
  typedef struct packed {
    logic signed [AngleW-1:0] last_out;
    logic [HoldW-1:0]         countdown;
    logic                     met_once;
  } ent_t;

endpackage

`default_nettype wire

FILE: src/jrsl_state.sv
`default_nettype none

module jrsl_state #(
  parameter int NUM_JOINTS = 32,
  localparam int IdxW = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                rd_en_i,
  input  wire logic [IdxW-1:0]     rd_idx_i,
  input  wire logic                wr_en_i,
  input  wire logic [IdxW-1:0]     wr_idx_i,
  input  wire jrsl_pkg::ent_t      wr_data_i,
  output jrsl_pkg::ent_t           rd_data_o,
  output logic                     rd_vld_o
);
  import jrsl_pkg::*;

  ent_t                  mem_q [NUM_JOINTS];
  ent_t                  rd_q;
  ent_t                  byp_q;
  logic                  hit_q;
  logic                  rd_vld_q;
  logic [NUM_JOINTS-1:0] vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_idx_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q  <= mem_q[rd_idx_i];
      byp_q <= wr_data_i;
    end
  end

  // read during write of the same entry takes the written word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      hit_q    <= 1'b0;
      rd_vld_q <= 1'b0;
    end else begin
      if (rd_en_i) begin
        hit_q    <= wr_en_i && (wr_idx_i == rd_idx_i);
        rd_vld_q <= vld_q[rd_idx_i];
      end
      if (wr_en_i) begin
        vld_q[wr_idx_i] <= 1'b1;
      end
    end
  end

  assign rd_data_o = hit_q ? byp_q : rd_q;
  assign rd_vld_o  = hit_q | rd_vld_q;

endmodule

`default_nettype wire

FILE: src/joint_reference_soft_limiter.sv
`default_nettype none

// Joint reference soft limiter.
// Input channel in_valid_i / in_stall_o / in_data_i carries one joint sample per
// transfer; output channel out_valid_o / out_stall_i / out_data_o returns one
// limited angle and three alarm flags per sample, in order.
// A sample is taken every cycle unless in_stall_o is high. Its result is
// registered in the memory stage and then in the output register, from
// which the receiver takes it. The per-joint state memory is read when the
// sample is taken and written back as it leaves the memory stage; a sample for
// the same joint taken at that edge gets the written word over a bypass path.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i (0 velocity
// margin, 1 servo hold ticks) in the same edge; write only while idle.
// Reset clears the per-joint valid bits, the register defaults and both
// handshakes; no clearing pass is needed, the block takes samples right away.
// When the receiver stalls, the output register holds its result, the memory
// stage holds its sample and in_stall_o rises once both are occupied.
module joint_reference_soft_limiter #(
  parameter int NUM_JOINTS = 32
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire jrsl_pkg::in_t                  in_data_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output jrsl_pkg::out_t                      out_data_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [jrsl_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [jrsl_pkg::CfgW-1:0]      cfg_data_i
);
  import jrsl_pkg::*;

  localparam int IdxW = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;
  localparam logic [8:0] NumJ = 9'(NUM_JOINTS);

  typedef struct packed {
    logic [JointW-1:0]        idx;
    logic                     in_rng;
    logic                     son;
    logic                     msk;
    logic signed [AngleW-1:0] ref_a;
    logic signed [AngleW-1:0] meas;
    logic signed [AngleW-1:0] ref_p;
    logic                     pos_ok;
    logic                     ref_lo;
    logic                     ref_hi;
    logic signed [33:0]       emax;
    logic signed [33:0]       emin;
    logic signed [33:0]       lo;
    logic signed [33:0]       hi;
  } stage_t;

  logic [MarginW-1:0] margin_q;
  logic [HoldW-1:0]   hold_q;

  stage_t b_d, b_q;
  logic   b_valid_q, b_valid_d;
  logic   b_adv;
  logic   in_fire;
  out_t   out_d, out_q;
  logic   out_valid_q, out_valid_d;

  ent_t   rd_ent;
  logic   rd_vld;
  ent_t   wr_ent;
  logic   wr_en;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      margin_q <= VelMarginRst;
      hold_q   <= ServoHoldRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgVelMargin: margin_q <= cfg_data_i[MarginW-1:0];
        CfgServoHold: hold_q   <= cfg_data_i[HoldW-1:0];
        default:      ;
      endcase
    end
  end

  // handshake
  assign b_adv      = !out_valid_q || !out_stall_i;
  assign in_stall_o = b_valid_q && !b_adv;
  assign in_fire    = in_valid_i && !in_stall_o;
  assign wr_en      = b_valid_q && b_adv && b_q.in_rng;

  always_comb begin
    b_valid_d = b_valid_q;
    if (in_fire) begin
      b_valid_d = 1'b1;
    end else if (b_adv) begin
      b_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (b_valid_q && b_adv) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      b_valid_q   <= b_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // state-independent precompute at the input transfer
  always_comb begin
    logic [AngleW-1:0]  lim;
    logic signed [33:0] meas34;
    logic signed [33:0] lim34;
    lim    = in_data_i.error_limit[AngleW-1] ? '0 : in_data_i.error_limit;
    meas34 = {{2{in_data_i.meas_angle[AngleW-1]}}, in_data_i.meas_angle};
    lim34  = $signed({2'b00, lim});
    b_d.idx    = in_data_i.joint_index;
    b_d.in_rng = ({4'b0000, in_data_i.joint_index} < NumJ);
    b_d.son    = in_data_i.servo_on;
    b_d.msk    = in_data_i.masked;
    b_d.ref_a  = in_data_i.ref_angle;
    b_d.meas   = in_data_i.meas_angle;
    b_d.pos_ok = in_data_i.pos_lower < in_data_i.pos_upper;
    b_d.ref_lo = in_data_i.ref_angle < in_data_i.pos_lower;
    b_d.ref_hi = in_data_i.ref_angle > in_data_i.pos_upper;
    b_d.ref_p  = b_d.ref_lo ? in_data_i.pos_lower : in_data_i.pos_upper;
    b_d.emax   = meas34 + lim34;
    b_d.emin   = meas34 - lim34;
    b_d.lo     = {{2{in_data_i.vel_lower_step[AngleW-1]}}, in_data_i.vel_lower_step}
                 + $signed({18'd0, margin_q});
    b_d.hi     = {{2{in_data_i.vel_upper_step[AngleW-1]}}, in_data_i.vel_upper_step}
                 - $signed({18'd0, margin_q});
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      b_q <= b_d;
    end
    if (b_valid_q && b_adv) begin
      out_q <= out_d;
    end
  end

  jrsl_state #(
    .NUM_JOINTS(NUM_JOINTS)
  ) u_state (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (in_fire),
    .rd_idx_i (IdxW'(in_data_i.joint_index)),
    .wr_en_i  (wr_en),
    .wr_idx_i (IdxW'(b_q.idx)),
    .wr_data_i(wr_ent),
    .rd_data_o(rd_ent),
    .rd_vld_o (rd_vld)
  );

  // memory stage: clamps and write-back
  always_comb begin
    logic [HoldW-1:0]         cd_old;
    logic [HoldW-1:0]         cd_new;
    logic                     met_old;
    logic                     active;
    logic signed [AngleW-1:0] prev;
    logic                     pa;
    logic                     ea;
    logic                     va;
    logic signed [33:0]       refx;
    logic signed [33:0]       refe;
    logic                     e_hi;
    logic                     e_lo;
    logic signed [34:0]       prev35;
    logic signed [34:0]       refe35;
    logic signed [34:0]       vmin;
    logic signed [34:0]       vmax;
    logic                     v_lo;
    logic                     v_hi;
    logic signed [34:0]       vres;
    logic signed [AngleW-1:0] vsat;
    logic signed [AngleW-1:0] lim_out;

    cd_old  = rd_vld ? rd_ent.countdown : '0;
    met_old = rd_vld ? rd_ent.met_once : 1'b0;
    prev    = rd_vld ? rd_ent.last_out : b_q.meas;

    if (b_q.son) begin
      cd_new = hold_q;
    end else if (cd_old != '0) begin
      cd_new = cd_old - 1'b1;
    end else begin
      cd_new = '0;
    end
    active = (cd_new != '0);

    pa   = active && met_old && b_q.pos_ok && (b_q.ref_lo || b_q.ref_hi);
    refx = pa ? {{2{b_q.ref_p[AngleW-1]}}, b_q.ref_p}
              : {{2{b_q.ref_a[AngleW-1]}}, b_q.ref_a};

    e_hi = refx > b_q.emax;
    e_lo = refx < b_q.emin;
    ea   = active && (e_hi || e_lo);
    refe = ea ? (e_hi ? b_q.emax : b_q.emin) : refx;

    prev35 = {{3{prev[AngleW-1]}}, prev};
    refe35 = {refe[33], refe};
    vmin   = prev35 + {b_q.lo[33], b_q.lo};
    vmax   = prev35 + {b_q.hi[33], b_q.hi};
    v_lo   = refe35 < vmin;
    v_hi   = refe35 > vmax;
    va     = active && (b_q.lo < b_q.hi) && (v_lo || v_hi);
    vres   = v_lo ? vmin : vmax;

    // saturate to the signed 32-bit range
    if (vres[34:31] == 4'b0000 || vres[34:31] == 4'b1111) begin
      vsat = vres[AngleW-1:0];
    end else if (vres[34]) begin
      vsat = {1'b1, {(AngleW-1){1'b0}}};
    end else begin
      vsat = {1'b0, {(AngleW-1){1'b1}}};
    end
    lim_out = va ? vsat : refe[AngleW-1:0];

    if (!b_q.in_rng || b_q.msk) begin
      out_d.out_angle        = b_q.ref_a;
      out_d.position_alarm   = 1'b0;
      out_d.error_alarm      = 1'b0;
      out_d.velocity_limited = 1'b0;
    end else begin
      out_d.out_angle        = lim_out;
      out_d.position_alarm   = pa;
      out_d.error_alarm      = ea;
      out_d.velocity_limited = va;
    end

    wr_ent.countdown = cd_new;
    if (b_q.msk) begin
      wr_ent.last_out = prev;
      wr_ent.met_once = met_old;
    end else begin
      wr_ent.last_out = lim_out;
      if (active && !b_q.ref_lo && !b_q.ref_hi) begin
        wr_ent.met_once = 1'b1;
      end else if (!active) begin
        wr_ent.met_once = 1'b0;
      end else begin
        wr_ent.met_once = met_old;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

FILE: bench/jrsl_checker.sv
`timescale 1ns / 1ps

module jrsl_checker #(
  parameter int NUM_JOINTS = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_stall_i,
  input  jrsl_pkg::in_t                in_data_i,
  input  logic                         out_valid_i,
  input  logic                         out_stall_i,
  input  jrsl_pkg::out_t               out_data_i,
  input  logic                         cfg_we_i,
  input  logic [jrsl_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [jrsl_pkg::CfgW-1:0]    cfg_data_i,
  output int                           mismatch_count_o,
  output int                           pending_o
);
  import jrsl_pkg::*;

  localparam longint AngleMax = 64'sd2147483647;
  localparam longint AngleMin = -64'sd2147483648;

  logic [MarginW-1:0]       margin_q = VelMarginRst;
  logic [HoldW-1:0]         hold_q = ServoHoldRst;
  logic signed [AngleW-1:0] last_angle [NUM_JOINTS];
  logic                     seen [NUM_JOINTS];
  logic [HoldW-1:0]         countdown [NUM_JOINTS];
  logic                     met_once [NUM_JOINTS];
  out_t                     limited_q [$];
  int                       mismatch_count = 0;

  initial begin
    mismatch_count_o = 0;
    pending_o = 0;
  end

  function automatic out_t limit_sample(input in_t s);
    out_t r;
    int k;
    logic active;
    longint ang, meas, plo, phi, lim, err, prev, lo, hi, stp;
    k = int'(s.joint_index);
    ang = longint'($signed(s.ref_angle));
    meas = longint'($signed(s.meas_angle));
    plo = longint'($signed(s.pos_lower));
    phi = longint'($signed(s.pos_upper));
    r = '0;
    // joint outside the table passes through untouched
    if (k >= NUM_JOINTS) begin
      r.out_angle = s.ref_angle;
      return r;
    end
    if (s.servo_on) begin
      countdown[k] = hold_q;
    end else if (countdown[k] != '0) begin
      countdown[k] = countdown[k] - 1'b1;
    end
    active = (countdown[k] != '0);
    if (!seen[k]) begin
      last_angle[k] = s.meas_angle;
      seen[k] = 1'b1;
    end
    if (!s.masked) begin
      // position clamp only once the reference was seen inside the limits
      if (active && plo <= ang && ang <= phi) begin
        met_once[k] = 1'b1;
      end else if (countdown[k] == '0) begin
        met_once[k] = 1'b0;
      end
      if (active && met_once[k] && plo < phi && (ang < plo || ang > phi)) begin
        ang = (ang < plo) ? plo : phi;
        r.position_alarm = 1'b1;
      end
      lim = longint'($signed(s.error_limit));
      if (lim < 0) lim = 0;
      err = ang - meas;
      if (err < 0) err = -err;
      if (active && err > lim) begin
        ang = (ang > meas + lim) ? meas + lim : meas - lim;
        r.error_alarm = 1'b1;
      end
      // step limits narrowed by the margin on both sides
      prev = longint'(last_angle[k]);
      lo = longint'($signed(s.vel_lower_step)) + longint'(margin_q);
      hi = longint'($signed(s.vel_upper_step)) - longint'(margin_q);
      stp = ang - prev;
      if (active && lo < hi && (stp < lo || stp > hi)) begin
        ang = (stp < lo) ? prev + lo : prev + hi;
        if (ang > AngleMax) ang = AngleMax;
        if (ang < AngleMin) ang = AngleMin;
        r.velocity_limited = 1'b1;
      end
      last_angle[k] = ang[AngleW-1:0];
    end
    r.out_angle = ang[AngleW-1:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    out_t want;
    if (!rst_ni) begin
      margin_q = VelMarginRst;
      hold_q = ServoHoldRst;
      for (int k = 0; k < NUM_JOINTS; k++) begin
        last_angle[k] = '0;
        seen[k] = 1'b0;
        countdown[k] = '0;
        met_once[k] = 1'b0;
      end
      limited_q.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (limited_q.size() == 0) begin
          $error("out_angle: expected no transfer, got %0d", out_data_i.out_angle);
          mismatch_count++;
        end else begin
          want = limited_q.pop_front();
          if (out_data_i.out_angle !== want.out_angle) begin
            $error("out_angle: expected %0d, got %0d", want.out_angle, out_data_i.out_angle);
            mismatch_count++;
          end
          if (out_data_i.position_alarm !== want.position_alarm) begin
            $error("position_alarm: expected %0b, got %0b", want.position_alarm,
                   out_data_i.position_alarm);
            mismatch_count++;
          end
          if (out_data_i.error_alarm !== want.error_alarm) begin
            $error("error_alarm: expected %0b, got %0b", want.error_alarm,
                   out_data_i.error_alarm);
            mismatch_count++;
          end
          if (out_data_i.velocity_limited !== want.velocity_limited) begin
            $error("velocity_limited: expected %0b, got %0b", want.velocity_limited,
                   out_data_i.velocity_limited);
            mismatch_count++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        limited_q.push_back(limit_sample(in_data_i));
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgVelMargin: margin_q = cfg_data_i[MarginW-1:0];
          CfgServoHold: hold_q = cfg_data_i[HoldW-1:0];
          default: ;
        endcase
      end
    end
    pending_o <= limited_q.size();
    mismatch_count_o <= mismatch_count;
  end

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import jrsl_pkg::*;

  localparam int NumJoints = 32;
  localparam int QuietLimit = 5000;
  localparam int HoldOffCycles = 80;
  localparam int NumPhases = 8;
  localparam int ItemsPerPhase = 235;
  localparam logic signed [AngleW-1:0] AngleMax = 32'sh7FFF_FFFF;
  localparam logic signed [AngleW-1:0] AngleMin = 32'sh8000_0000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  in_t                in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  out_t               out_data;
  logic               cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx = '0;
  logic [CfgW-1:0]    cfg_data = '0;

  int mismatch_count;
  int pending;
  int sender_idle_pct = 0;
  int stall_pct = 0;
  int hold_off_left = 0;
  int quiet_cycles = 0;
  int drift_angle [NumJoints];

  always #10 clk = ~clk;

  joint_reference_soft_limiter #(
    .NUM_JOINTS(NumJoints)
  ) uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  jrsl_checker #(
    .NUM_JOINTS(NumJoints)
  ) limiter_check (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .in_data_i       (in_data),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .out_data_i      (out_data),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .mismatch_count_o(mismatch_count),
    .pending_o       (pending)
  );

  // receiver, with a long hold-off counted down here
  always @(posedge clk) begin
    if (hold_off_left > 0) begin
      out_stall <= 1'b1;
      hold_off_left <= hold_off_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("joint_reference_soft_limiter: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic in_t joint_sample(input int j, input logic signed [AngleW-1:0] ang,
                                       input logic signed [AngleW-1:0] meas,
                                       input logic son,
                                       input logic signed [AngleW-1:0] plo,
                                       input logic signed [AngleW-1:0] phi,
                                       input logic signed [AngleW-1:0] vlo,
                                       input logic signed [AngleW-1:0] vhi,
                                       input logic signed [AngleW-1:0] elim,
                                       input logic msk);
    in_t s;
    s.joint_index = JointW'(j);
    s.ref_angle = ang;
    s.meas_angle = meas;
    s.servo_on = son;
    s.pos_lower = plo;
    s.pos_upper = phi;
    s.vel_lower_step = vlo;
    s.vel_upper_step = vhi;
    s.error_limit = elim;
    s.masked = msk;
    return s;
  endfunction

  // mostly plausible joint streams around a drifting angle, some pure noise
  function automatic in_t make_sample();
    in_t s;
    int j, base, span, reach, speed;
    if ($urandom_range(99) < 15) begin
      s.joint_index = JointW'($urandom_range(31));
      s.ref_angle = $urandom;
      s.meas_angle = $urandom;
      s.servo_on = 1'($urandom_range(1));
      s.pos_lower = $urandom;
      s.pos_upper = $urandom;
      s.vel_lower_step = $urandom;
      s.vel_upper_step = $urandom;
      s.error_limit = $urandom;
      s.masked = 1'($urandom_range(1));
      return s;
    end
    j = ($urandom_range(99) < 60) ? $urandom_range(3) : $urandom_range(31);
    base = drift_angle[j];
    case ($urandom_range(2))
      0: span = 300;
      1: span = 20000;
      default: span = 600000;
    endcase
    reach = $urandom_range(200000);
    speed = $urandom_range(1 << 18);
    s.joint_index = JointW'(j);
    s.meas_angle = base + int'($urandom_range(4000)) - 2000;
    s.ref_angle = s.meas_angle + int'($urandom_range(2 * span)) - span;
    s.pos_lower = base - reach;
    s.pos_upper = base + reach;
    if ($urandom_range(9) == 0) begin
      s.pos_lower = base + reach;
      s.pos_upper = base - reach;
    end
    s.vel_lower_step = -speed;
    s.vel_upper_step = speed;
    if ($urandom_range(9) == 0) begin
      s.vel_lower_step = $urandom;
      s.vel_upper_step = $urandom;
    end
    s.error_limit = int'($urandom_range(400000)) - 30000;
    s.servo_on = ($urandom_range(99) < 88);
    s.masked = ($urandom_range(99) < 4);
    drift_angle[j] = base + int'($urandom_range(40000)) - 20000;
    return s;
  endfunction

  // valid stays high after the transfer until the next call or settle
  task automatic send_sample(input in_t s);
    int gap;
    gap = 0;
    while ($urandom_range(99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_regs(input logic [CfgW-1:0] margin_word,
                            input logic [CfgW-1:0] hold_word);
    cfg_we <= 1'b1;
    cfg_idx <= CfgVelMargin;
    cfg_data <= margin_word;
    @(posedge clk);
    cfg_idx <= CfgServoHold;
    cfg_data <= hold_word;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_directed();
    // masked first sample, then all three clamps on one joint
    send_sample(joint_sample(0, 5, 100, 1'b1, 0, 1000, -50, 50, 1000, 1'b1));
    send_sample(joint_sample(0, 200, 100, 1'b1, 0, 1000, -50, 50, 1000, 1'b0));
    send_sample(joint_sample(0, 5000, 100, 1'b1, 0, 1000, -50, 50, 300, 1'b0));
    // negative error limit acts as zero
    send_sample(joint_sample(0, 101, 100, 1'b1, 0, 1000, -1000000, 1000000, -5, 1'b0));
    // inverted position limits, then step limits that meet once narrowed by the margin
    send_sample(joint_sample(0, 5000, 4000, 1'b1, 1000, 0, -1000000, 1000000, 100000,
                             1'b0));
    send_sample(joint_sample(0, -3000, -3000, 1'b1, AngleMin, AngleMax, 10, 22, 100000,
                             1'b0));
    // servo off: countdown runs out and clamps stop
    for (int n = 0; n < 10; n++) begin
      send_sample(joint_sample(0, 50000000, 0, 1'b0, 0, 1000, -50, 50, 0, 1'b0));
    end
    send_sample(joint_sample(5, AngleMin, AngleMax, 1'b1, AngleMin, AngleMax, AngleMin,
                             AngleMax, AngleMax, 1'b0));
    // step clamp saturating at both ends
    send_sample(joint_sample(3, 32'sh7FFF_0000, 32'sh7FFF_0000, 1'b1, AngleMin, AngleMax,
                             AngleMin, AngleMax, AngleMax, 1'b0));
    send_sample(joint_sample(3, 0, 0, 1'b1, AngleMin, AngleMax, 32'sh7FFF_0000, AngleMax,
                             AngleMax, 1'b0));
    send_sample(joint_sample(4, 32'sh8001_0000, 32'sh8001_0000, 1'b1, AngleMin, AngleMax,
                             AngleMin, AngleMax, AngleMax, 1'b0));
    send_sample(joint_sample(4, 0, 0, 1'b1, AngleMin, AngleMax, AngleMin, 32'sh8001_0000,
                             AngleMax, 1'b0));
    send_sample(joint_sample(31, -1, -1, 1'b1, -1, -1, -1, -1, -1, 1'b1));
  endtask

  initial begin
    logic [CfgW-1:0] margin_word;
    logic [HoldW-1:0] hold_val;
    for (int j = 0; j < NumJoints; j++) drift_angle[j] = int'($urandom) >>> 3;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    for (int p = 0; p < NumPhases; p++) begin
      settle();
      repeat (2) @(posedge clk);
      case (p)
        0: begin margin_word = VelMarginRst; hold_val = ServoHoldRst; end
        1: begin margin_word = '0; hold_val = '0; end
        2: begin margin_word = '1; hold_val = '1; end
        3: begin margin_word = '0; hold_val = 4'd1; end
        4: begin
          margin_word = CfgW'($urandom_range(2000));
          hold_val = HoldW'($urandom_range(15));
        end
        5: begin margin_word = 16'd1; hold_val = 4'd2; end
        6: begin margin_word = '1; hold_val = HoldW'($urandom_range(15)); end
        default: begin
          margin_word = CfgW'($urandom);
          hold_val = HoldW'($urandom_range(15));
        end
      endcase
      write_regs(margin_word, (CfgW'($urandom) & ~CfgW'(4'hF)) | CfgW'(hold_val));
      case (p % 4)
        0: begin sender_idle_pct = 0; stall_pct <= 0; end
        1: begin sender_idle_pct = 72; stall_pct <= 0; end
        2: begin sender_idle_pct = 0; stall_pct <= 72; end
        default: begin sender_idle_pct = 24; stall_pct <= 24; end
      endcase
      for (int i = 0; i < ItemsPerPhase; i++) begin
        if (p == 0 && i == 60) hold_off_left <= HoldOffCycles;
        if (p == 2 && i == 120) settle();
        send_sample(make_sample());
      end
    end
    settle();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && pending == 0) begin
      $display("joint_reference_soft_limiter: match");
    end else begin
      $display("joint_reference_soft_limiter: mismatch");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/jrsl_pkg.sv
src/jrsl_state.sv
src/joint_reference_soft_limiter.sv
bench/jrsl_checker.sv
bench/testbench.sv
